/* rtl/bcis_pkg.sv */
// Shared types and constants for the byte CPU instruction step unit.
package bcis_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EXEC  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_RUN      = 3'd0,
        ST_HALT     = 3'd1,
        ST_PC_LIMIT = 3'd2,
        ST_PC_WRITE = 3'd3,
        ST_BAD_REG  = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_UNDERFLW = 3'd6,
        ST_BAD_OP   = 3'd7
    } status_t;

    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_SUB  = 5'd1;
    localparam logic [4:0] OP_LD   = 5'd2;
    localparam logic [4:0] OP_MV   = 5'd3;
    localparam logic [4:0] OP_JMP  = 5'd4;
    localparam logic [4:0] OP_ADDR = 5'd5;
    localparam logic [4:0] OP_SUBR = 5'd6;
    localparam logic [4:0] OP_XOR  = 5'd7;
    localparam logic [4:0] OP_AND  = 5'd8;
    localparam logic [4:0] OP_OR   = 5'd9;
    localparam logic [4:0] OP_NAND = 5'd10;
    localparam logic [4:0] OP_NOT  = 5'd11;
    localparam logic [4:0] OP_SHFT = 5'd12;
    localparam logic [4:0] OP_ST   = 5'd13;
    localparam logic [4:0] OP_RET  = 5'd14;
    localparam logic [4:0] OP_CMP  = 5'd15;
    localparam logic [4:0] OP_JE   = 5'd16;
    localparam logic [4:0] OP_JNE  = 5'd17;
    localparam logic [4:0] OP_JG   = 5'd18;
    localparam logic [4:0] OP_JL   = 5'd19;
    localparam logic [4:0] OP_PUSH = 5'd20;
    localparam logic [4:0] OP_POP  = 5'd21;
    localparam logic [4:0] OP_HALT = 5'd22;

    localparam logic [7:0]  REG_FLAGS = 8'd1;
    localparam logic [7:0]  REG_SP    = 8'd2;
    localparam logic [7:0]  REG_PC    = 8'd3;
    localparam logic [7:0]  REG_GP_LO = 8'd4;
    localparam logic [7:0]  REG_GP_HI = 8'h0E;
    localparam logic [15:0] STACK_BASE = 16'hF000;
    localparam logic [15:0] PC_LIMIT   = 16'h7FFE;
    localparam logic [7:0]  SP_FULL    = 8'd255;
    localparam logic [7:0]  SP_RESET   = 8'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  data;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  run_status;
        logic [15:0] program_counter;
        logic [7:0]  flag_register;
        logic [7:0]  stack_index;
    } out_item_t;

    // Request from the sequencer to the memory module.
    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

endpackage

/* rtl/bcis_mem.sv */
// Main byte memory, one synchronous port with registered read data.
module bcis_mem #(
    parameter int MEM_BYTES = 65536
) (
    input  logic               clk,
    input  bcis_pkg::mem_req_t req,
    output logic [7:0]         rdata
);
    import bcis_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr[AW-1:0]] <= req.wdata;
            end
            rdata_reg <= mem[req.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bcis_seq.sv */
// Instruction sequencer: memory read/write commands, fetch, register resolve, execute and stack access.
module bcis_seq #(
    parameter int GP_COUNT = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bcis_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bcis_pkg::out_item_t  out_item,
    output bcis_pkg::mem_req_t   mreq,
    input  logic [7:0]           mrdata
);
    import bcis_pkg::*;

    localparam int GW = $clog2(GP_COUNT);

    typedef enum logic [3:0] {
        S_IDLE, S_MEMRD, S_RDWAIT, S_FETCH, S_FWAIT, S_DECODE,
        S_DATARD, S_DWAIT, S_PUSH, S_POP, S_PWAIT, S_DONE
    } state_t;

    state_t      state_reg;
    logic [7:0]  gp_reg [GP_COUNT];
    logic [7:0]  flags_reg, sp_reg;
    logic [15:0] pc_reg;
    status_t     stop_reg;
    logic [4:0]  op_reg;
    logic [2:0]  nfetch_reg;   // bytes of the instruction fetched so far
    logic [7:0]  b1_reg, b2_reg, b3_reg;
    logic [15:0] daddr_reg;
    logic [7:0]  rd_reg, popb_reg;
    logic [1:0]  npush_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;
    mem_req_t    mreq_c;

    // Total bytes an opcode occupies, including itself.
    function automatic logic [2:0] op_len(input logic [4:0] op);
        case (op)
            OP_ADD, OP_SUB, OP_MV, OP_ADDR, OP_SUBR, OP_XOR, OP_AND,
            OP_OR, OP_NAND, OP_SHFT, OP_CMP: op_len = 3'd3;
            OP_LD, OP_ST, OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JL: op_len = 3'd3;
            OP_NOT, OP_PUSH, OP_POP: op_len = 3'd2;
            default: op_len = 3'd1;
        endcase
        if (op == OP_LD || op == OP_ST)
        begin
            op_len = 3'd4;
        end
    endfunction

    // Which operand bytes are register codes.
    function automatic logic is_reg_byte(input logic [4:0] op, input logic [2:0] idx);
        logic r;
        r = 1'b0;
        case (op)
            OP_ADD, OP_SUB, OP_LD, OP_ST, OP_NOT, OP_POP: r = (idx == 3'd1);
            OP_MV, OP_ADDR, OP_SUBR, OP_XOR, OP_AND, OP_OR, OP_NAND, OP_SHFT:
                r = (idx == 3'd1) || (idx == 3'd2);
            default: r = 1'b0;
        endcase
        is_reg_byte = r;
    endfunction

    function automatic status_t reg_err(input logic [7:0] c);
        if (c == REG_PC)
        begin
            reg_err = ST_PC_WRITE;
        end
        else if (c == 8'd0 || c > REG_GP_HI)
        begin
            reg_err = ST_BAD_REG;
        end
        else
        begin
            reg_err = ST_RUN;
        end
    endfunction

    function automatic logic op_known(input logic [4:0] op);
        op_known = (op <= OP_HALT);
    endfunction

    function automatic logic [7:0] shift_val(input logic [7:0] v, input logic [7:0] amt);
        logic [8:0] n;
        n = {1'b0, amt} - 9'd8;
        if (amt >= 8'd16 || amt <= 8'd0)
        begin
            shift_val = 8'd0;
        end
        else if (amt >= 8'd8)
        begin
            shift_val = v << n[2:0];
        end
        else
        begin
            shift_val = v >> (4'd8 - {1'b0, amt[2:0]});
        end
    endfunction

    logic [7:0] rval1, rval2, result;
    logic       take;

    function automatic logic [7:0] read_reg(input logic [7:0] c, input logic [7:0] fl,
                                           input logic [7:0] sp, input logic [7:0] gv);
        if (c == REG_FLAGS)
        begin
            read_reg = fl;
        end
        else if (c == REG_SP)
        begin
            read_reg = sp;
        end
        else
        begin
            read_reg = gv;
        end
    endfunction

    logic [7:0] gidx1_w, gidx2_w;
    logic [GW-1:0] gidx1, gidx2;
    assign gidx1_w = b1_reg - REG_GP_LO;
    assign gidx2_w = b2_reg - REG_GP_LO;
    assign gidx1 = gidx1_w[GW-1:0];
    assign gidx2 = gidx2_w[GW-1:0];
    assign rval1 = read_reg(b1_reg, flags_reg, sp_reg, gp_reg[gidx1]);
    assign rval2 = read_reg(b2_reg, flags_reg, sp_reg, gp_reg[gidx2]);

    always_comb
    begin
        case (op_reg)
            OP_ADD:  result = rval1 + b2_reg;
            OP_SUB:  result = rval1 - b2_reg;
            OP_MV:   result = rval1;
            OP_ADDR: result = rval1 + rval2;
            OP_SUBR: result = rval1 - rval2;
            OP_XOR:  result = rval1 ^ rval2;
            OP_AND:  result = rval1 & rval2;
            OP_OR:   result = rval1 | rval2;
            OP_NAND: result = ~(rval1 & rval2);
            OP_NOT:  result = ~rval1;
            OP_SHFT: result = shift_val(rval1, rval2);
            default: result = mrdata;
        endcase
        case (op_reg)
            OP_JE:   take = (flags_reg == 8'd1);
            OP_JNE:  take = (flags_reg != 8'd1);
            OP_JG:   take = (flags_reg == 8'd0);
            OP_JL:   take = (flags_reg == 8'd2);
            default: take = 1'b1;
        endcase
    end

    always_comb
    begin
        mreq_c = '0;
        case (state_reg)
            S_MEMRD:
            begin
                mreq_c.en = 1'b1;
                mreq_c.we = (in_item.command == CMD_WRITE);
                mreq_c.addr = in_item.address;
                mreq_c.wdata = in_item.data;
            end
            S_FETCH:
            begin
                mreq_c.en = (pc_reg <= PC_LIMIT);
                mreq_c.addr = pc_reg;
            end
            S_DATARD:
            begin
                mreq_c.en = 1'b1;
                mreq_c.we = (op_reg == OP_ST);
                mreq_c.addr = daddr_reg;
                mreq_c.wdata = rval1;
            end
            S_PUSH:
            begin
                mreq_c.en = (sp_reg != SP_FULL);
                mreq_c.we = 1'b1;
                mreq_c.addr = STACK_BASE + {8'd0, sp_reg};
                mreq_c.wdata = (op_reg == OP_PUSH) ? b1_reg :
                               (npush_reg == 2'd0) ? pc_reg[7:0] : pc_reg[15:8];
            end
            S_POP:
            begin
                mreq_c.en = (sp_reg != 8'd0);
                mreq_c.addr = STACK_BASE + {8'd0, sp_reg - 8'd1};
            end
            default: mreq_c = '0;
        endcase
    end
    assign mreq = mreq_c;

    logic [7:0] wreg;
    assign wreg = (op_reg == OP_MV) ? b2_reg : b1_reg;
    logic [7:0] widx_w;
    logic [GW-1:0] widx;
    assign widx_w = wreg - REG_GP_LO;
    assign widx = widx_w[GW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < GP_COUNT; i++)
            begin
                gp_reg[i] <= 8'd0;
            end
            flags_reg     <= 8'd0;
            sp_reg        <= SP_RESET;
            pc_reg        <= 16'd0;
            stop_reg      <= ST_RUN;
            out_valid_reg <= 1'b0;
            op_reg        <= '0;
            nfetch_reg    <= '0;
            npush_reg     <= '0;
            rd_reg        <= '0;
            b1_reg        <= '0;
            b2_reg        <= '0;
            b3_reg        <= '0;
            daddr_reg     <= '0;
            popb_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        rd_reg <= 8'd0;
                        if (in_item.command == CMD_WRITE || in_item.command == CMD_READ)
                        begin
                            state_reg <= S_MEMRD;
                        end
                        else if (in_item.command == CMD_EXEC && stop_reg == ST_RUN)
                        begin
                            nfetch_reg <= 3'd0;
                            state_reg  <= S_FETCH;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_MEMRD:   state_reg <= S_RDWAIT;
                S_RDWAIT:
                begin
                    if (in_item.command == CMD_READ)
                    begin
                        rd_reg <= mrdata;
                    end
                    state_reg <= S_DONE;
                end
                S_FETCH:
                begin
                    if (pc_reg > PC_LIMIT)
                    begin
                        stop_reg  <= ST_PC_LIMIT;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pc_reg    <= pc_reg + 16'd1;
                        state_reg <= S_FWAIT;
                    end
                end
                S_FWAIT:
                begin
                    nfetch_reg <= nfetch_reg + 3'd1;
                    case (nfetch_reg)
                        3'd0:
                        begin
                            op_reg <= mrdata[4:0];
                            if (mrdata > {3'd0, OP_HALT})
                            begin
                                stop_reg  <= ST_BAD_OP;
                                state_reg <= S_DONE;
                            end
                            else if (mrdata[4:0] == OP_HALT)
                            begin
                                stop_reg  <= ST_HALT;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                // Compare clears the flags before its operands are fetched.
                                if (mrdata[4:0] == OP_CMP)
                                begin
                                    flags_reg <= 8'd0;
                                end
                                state_reg <= (op_len(mrdata[4:0]) == 3'd1) ? S_DECODE : S_FETCH;
                            end
                        end
                        3'd1: b1_reg <= mrdata;
                        3'd2: b2_reg <= mrdata;
                        default: b3_reg <= mrdata;
                    endcase
                    if (nfetch_reg != 3'd0)
                    begin
                        if (is_reg_byte(op_reg, nfetch_reg) && reg_err(mrdata) != ST_RUN)
                        begin
                            stop_reg  <= reg_err(mrdata);
                            state_reg <= S_DONE;
                        end
                        else if (nfetch_reg + 3'd1 == op_len(op_reg))
                        begin
                            state_reg <= S_DECODE;
                        end
                        else
                        begin
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_DECODE:
                begin
                    npush_reg <= 2'd0;
                    case (op_reg)
                        OP_LD, OP_ST:
                        begin
                            daddr_reg <= {b3_reg, b2_reg};
                            state_reg <= S_DATARD;
                        end
                        OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JL:
                        begin
                            daddr_reg <= {b2_reg, b1_reg};
                            state_reg <= take ? S_PUSH : S_DONE;
                        end
                        OP_PUSH: state_reg <= S_PUSH;
                        OP_RET, OP_POP:
                        begin
                            state_reg <= S_POP;
                        end
                        OP_CMP:
                        begin
                            flags_reg <= (b2_reg > b1_reg) ? 8'd2 :
                                         (b2_reg == b1_reg) ? 8'd1 : 8'd0;
                            state_reg <= S_DONE;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                            if (op_known(op_reg))
                            begin
                                if (wreg == REG_FLAGS)
                                begin
                                    flags_reg <= result;
                                end
                                else if (wreg == REG_SP)
                                begin
                                    sp_reg <= result;
                                end
                                else
                                begin
                                    gp_reg[widx] <= result;
                                end
                            end
                        end
                    endcase
                end
                S_DATARD:  state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (op_reg == OP_LD)
                    begin
                        if (b1_reg == REG_FLAGS)
                        begin
                            flags_reg <= mrdata;
                        end
                        else if (b1_reg == REG_SP)
                        begin
                            sp_reg <= mrdata;
                        end
                        else
                        begin
                            gp_reg[gidx1] <= mrdata;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_PUSH:
                begin
                    if (sp_reg == SP_FULL)
                    begin
                        stop_reg  <= ST_OVERFLOW;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg + 8'd1;
                        npush_reg <= npush_reg + 2'd1;
                        if (op_reg == OP_PUSH || npush_reg == 2'd1)
                        begin
                            if (op_reg != OP_PUSH)
                            begin
                                pc_reg <= daddr_reg;
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_POP:
                begin
                    if (sp_reg == 8'd0)
                    begin
                        stop_reg  <= ST_UNDERFLW;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg - 8'd1;
                        state_reg <= S_PWAIT;
                    end
                end
                S_PWAIT:
                begin
                    if (op_reg == OP_POP)
                    begin
                        state_reg <= S_DONE;
                        if (b1_reg == REG_FLAGS)
                        begin
                            flags_reg <= mrdata;
                        end
                        else if (b1_reg == REG_SP)
                        begin
                            sp_reg <= mrdata;
                        end
                        else
                        begin
                            gp_reg[gidx1] <= mrdata;
                        end
                    end
                    else if (npush_reg == 2'd0)
                    begin
                        popb_reg  <= mrdata;
                        npush_reg <= 2'd1;
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        pc_reg    <= {popb_reg, mrdata};
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_reg.read_data       <= rd_reg;
                        out_reg.run_status      <= stop_reg;
                        out_reg.program_counter <= pc_reg;
                        out_reg.flag_register   <= flags_reg;
                        out_reg.stack_index     <= sp_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // The input item is held (stalled) until its result is queued.
    assign in_stall  = !(state_reg == S_DONE && (!out_valid_reg || !out_stall));
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    property p_hold;
        @(posedge clk) disable iff (!rst_n) out_valid && out_stall |=> out_valid;
    endproperty
    assert property (p_hold) else $error("result dropped while stalled");

    property p_stop_sticky;
        @(posedge clk) disable iff (!rst_n)
            $past(stop_reg) != ST_RUN |-> stop_reg == $past(stop_reg);
    endproperty
    assert property (p_stop_sticky) else $error("stop code changed");

    property p_accept_done;
        @(posedge clk) disable iff (!rst_n) !in_stall |-> state_reg == S_DONE;
    endproperty
    assert property (p_accept_done) else $error("item taken outside completion");

endmodule

/* rtl/byte_cpu_instruction_step_unit.sv */
// Top level of the byte CPU instruction step unit.
// Usage: one input channel (in_valid/in_stall/in_item) carries commands:
// write a memory byte, read a memory byte, or execute one instruction.
// Each item gives exactly one result on out_valid/out_stall/out_item
// with read data, run status, pc, flags and stack pointer.
// The item is accepted at the edge where its result enters the output
// register, so in_stall is high while an item is being worked on.
// Read or write: a memory access, then a wait for the registered read data.
// Execute fetches each instruction byte the same way, then decodes, then makes
// any data access, pushes or pops. One item completes before the next starts.
// All accesses share the single memory port with registered read data.
// After reset registers and flags are zero, the stack pointer is one and
// the pc is zero; memory holds no defined value until written.
// A stalled result stays in the output register; the next item may work
// up to its completion and then waits for the register to empty.
module byte_cpu_instruction_step_unit #(
    parameter int MEM_BYTES = 65536,
    parameter int GP_COUNT  = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bcis_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output bcis_pkg::out_item_t out_item
);
    import bcis_pkg::*;

    mem_req_t   mreq;
    logic [7:0] mrdata;

    bcis_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .clk   (clk),
        .req   (mreq),
        .rdata (mrdata)
    );

    bcis_seq #(.GP_COUNT(GP_COUNT)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .mreq      (mreq),
        .mrdata    (mrdata)
    );

endmodule
